>>> hdl/dccd_pkg.sv
// Shared constants and types for the DMX channel change detector.
`default_nettype none
package dccd_pkg;

    localparam int CHANNELS_DEFAULT = 512;
    localparam int OFFSET_W         = 10;
    localparam int LENGTH_W         = 16;
    localparam int INDEX_W          = 9;
    localparam int LEVEL_W          = 8;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

    // header layout, in byte offsets
    localparam logic [OFFSET_W-1:0] OFF_OPCODE_LO = OFFSET_W'(8);
    localparam logic [OFFSET_W-1:0] OFF_OPCODE_HI = OFFSET_W'(9);
    localparam logic [OFFSET_W-1:0] OFF_COUNT_HI  = OFFSET_W'(16);
    localparam logic [OFFSET_W-1:0] OFF_COUNT_LO  = OFFSET_W'(17);
    localparam logic [OFFSET_W-1:0] HEADER_LEN    = OFFSET_W'(18);
    localparam logic [OFFSET_W-1:0] OFFSET_MAX    = {OFFSET_W{1'b1}};

    localparam logic [15:0] OPCODE_DMX = 16'h5000;
    localparam logic [15:0] MIN_COUNT  = 16'd2;

    // one used channel byte, handed from parser to store
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [LEVEL_W-1:0] level;
    } item_t;

endpackage
`default_nettype wire

>>> hdl/dccd_front.sv
// Header parser: tracks byte offset, decides packet validity, picks out channel bytes.
`default_nettype none
module dccd_front #(
    parameter int CHANNELS = dccd_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          accept,
    input  wire logic [dccd_pkg::LEVEL_W-1:0]  data_byte,
    input  wire logic [dccd_pkg::LENGTH_W-1:0] datagram_length,
    input  wire logic                          first_byte,
    output logic                               push,
    output dccd_pkg::item_t                    push_item
);

    localparam logic [16:0] MAX_LEN = 17'(dccd_pkg::HEADER_LEN) + 17'(CHANNELS);

    logic [dccd_pkg::OFFSET_W-1:0] offset_reg, offset_next, off;
    logic [15:0]                   opcode_reg, opcode_next, opcode_eff;
    logic [15:0]                   count_reg, count_next, count_eff;
    logic [15:0]                   length_reg, length_next;
    logic [dccd_pkg::OFFSET_W-1:0] active_reg, active_next, active_eff;
    logic                          pvalid_reg, pvalid_next, pvalid_eff;
    logic                          decide_ok;
    logic [15:0]                   avail, min_val;
    logic [dccd_pkg::OFFSET_W-1:0] ch;

    always_comb begin
        off        = first_byte ? '0 : offset_reg;
        opcode_eff = first_byte ? '0 : opcode_reg;
        count_eff  = first_byte ? '0 : count_reg;
        active_eff = first_byte ? '0 : active_reg;
        pvalid_eff = first_byte ? 1'b0 : pvalid_reg;
        length_next = first_byte ? datagram_length : length_reg;

        opcode_next = opcode_eff;
        count_next  = count_eff;
        active_next = active_eff;
        pvalid_next = pvalid_eff;
        ch          = off - dccd_pkg::HEADER_LEN;

        // decision at the last header byte uses the low count byte just arriving
        decide_ok = ({1'b0, length_reg} <= MAX_LEN)
                    && (opcode_reg == dccd_pkg::OPCODE_DMX)
                    && ({count_reg[15:8], data_byte} >= dccd_pkg::MIN_COUNT);
        avail   = length_reg - 16'(dccd_pkg::HEADER_LEN);
        min_val = ({count_reg[15:8], data_byte} < avail) ? {count_reg[15:8], data_byte}
                                                         : avail;
        push = 1'b0;

        case (off)
            dccd_pkg::OFF_OPCODE_LO: opcode_next = {opcode_eff[15:8], data_byte};
            dccd_pkg::OFF_OPCODE_HI: opcode_next = {data_byte, opcode_eff[7:0]};
            dccd_pkg::OFF_COUNT_HI:  count_next  = {data_byte, count_eff[7:0]};
            dccd_pkg::OFF_COUNT_LO: begin
                count_next  = {count_eff[15:8], data_byte};
                pvalid_next = decide_ok;
                active_next = '0;
                if (decide_ok && length_reg >= 16'(dccd_pkg::HEADER_LEN)) begin
                    active_next = min_val[dccd_pkg::OFFSET_W-1:0];
                end
            end
            default: begin
                push = accept && (off >= dccd_pkg::HEADER_LEN) && pvalid_eff
                       && (ch < active_eff);
            end
        endcase

        offset_next = (off < dccd_pkg::OFFSET_MAX) ? off + 1'b1 : off;
        push_item.index = ch[dccd_pkg::INDEX_W-1:0];
        push_item.level = data_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            opcode_reg <= '0;
            count_reg  <= '0;
            length_reg <= '0;
            active_reg <= '0;
            pvalid_reg <= 1'b0;
        end else if (accept) begin
            offset_reg <= offset_next;
            opcode_reg <= opcode_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            active_reg <= active_next;
            pvalid_reg <= pvalid_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/dccd_queue.sv
// Small FIFO between parser and level store.
`default_nettype none
module dccd_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire dccd_pkg::item_t push_item,
    output logic                 has_room,
    input  wire logic            pop,
    output logic                 q_valid,
    output dccd_pkg::item_t      q_item
);

    localparam logic [dccd_pkg::QPTR_W:0] DEPTH = (dccd_pkg::QPTR_W + 1)'(dccd_pkg::QUEUE_DEPTH);

    dccd_pkg::item_t             entry_reg [dccd_pkg::QUEUE_DEPTH];
    logic [dccd_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [dccd_pkg::QPTR_W:0]   count_reg, count_next;

    assign has_room = (count_reg != DEPTH);
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/dccd_back.sv
// Level store with read-compare-write and the output register.
`default_nettype none
module dccd_back #(
    parameter int CHANNELS = dccd_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire dccd_pkg::item_t               q_item,
    output logic                               pop,
    output logic                               clr_busy,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [dccd_pkg::INDEX_W-1:0]       out_index,
    output logic [dccd_pkg::LEVEL_W-1:0]       out_level
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(CHANNELS - 1);

    logic [dccd_pkg::LEVEL_W-1:0] store_mem [CHANNELS];
    logic [dccd_pkg::LEVEL_W-1:0] rd_data_reg;

    logic                         clr_busy_reg;
    logic [AW-1:0]                clr_addr_reg;

    logic                         s2_valid_reg;
    dccd_pkg::item_t              s2_item_reg;
    logic                         s2_byp_reg;
    logic [dccd_pkg::LEVEL_W-1:0] s2_byp_data_reg;

    logic                         out_valid_reg;
    logic [dccd_pkg::INDEX_W-1:0] out_index_reg;
    logic [dccd_pkg::LEVEL_W-1:0] out_level_reg;

    logic [dccd_pkg::LEVEL_W-1:0] old_level;
    logic                         changed, out_free, s2_done, s2_wr, byp;

    always_comb begin
        old_level = s2_byp_reg ? s2_byp_data_reg : rd_data_reg;
        changed   = (old_level != s2_item_reg.level);
        out_free  = !out_valid_reg || out_ready;
        s2_done   = s2_valid_reg && (!changed || out_free);
        s2_wr     = s2_valid_reg && changed && out_free;
        pop       = q_valid && !clr_busy_reg && (!s2_valid_reg || s2_done);
        // same-edge write to the address being read: the array still shows the old level
        byp       = s2_wr && (s2_item_reg.index[AW-1:0] == q_item.index[AW-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            store_mem[clr_addr_reg] <= '0;
        end else if (s2_wr) begin
            store_mem[s2_item_reg.index[AW-1:0]] <= s2_item_reg.level;
        end
        if (pop) begin
            rd_data_reg <= store_mem[q_item.index[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s2_item_reg     <= q_item;
            s2_byp_reg      <= byp;
            s2_byp_data_reg <= s2_item_reg.level;
        end
        if (s2_wr) begin
            out_index_reg <= s2_item_reg.index;
            out_level_reg <= s2_item_reg.level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (pop) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_done) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_wr) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign clr_busy  = clr_busy_reg;
    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_level = out_level_reg;

endmodule
`default_nettype wire

>>> hdl/dmx_channel_change_detector_unit.sv
// Top level of the DMX channel change detector: parser, queue and level store.
// Throughput: one payload byte per cycle while s_tready is high,
//   set by the single store read and write port that each channel byte uses once.
// Path: a changed level passes the queue entry, the stage-2 register and the output register to m_tvalid.
// Reset: synchronous, active low; afterwards the level store is zeroed one entry
//   per cycle, all CHANNELS entries, with s_tready held low during that pass.
`default_nettype none
module dmx_channel_change_detector_unit #(
    parameter int CHANNELS = dccd_pkg::CHANNELS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input item channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] datagram_length
    input  wire logic        s_tuser,   // [0] first_byte
    // result item channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [8:0] channel_index, [16:9] channel_level, rest 0
);

    logic                          accept;
    logic                          push, has_room, pop, q_valid, clr_busy;
    dccd_pkg::item_t               push_item, q_item;
    logic [dccd_pkg::INDEX_W-1:0]  out_index;
    logic [dccd_pkg::LEVEL_W-1:0]  out_level;

    // stall the input while the store is being zeroed or the queue is full
    assign s_tready = has_room && !clr_busy;
    assign accept   = s_tvalid && s_tready;

    // front: tracks header, emits only bytes of used channels
    dccd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .data_byte       (s_tdata[7:0]),
        .datagram_length (s_tdata[23:8]),
        .first_byte      (s_tuser),
        .push            (push),
        .push_item       (push_item)
    );

    // decouples the parser from stalls on the result side
    dccd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .has_room  (has_room),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // back: read stored level, compare, write back and emit on change
    dccd_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .clr_busy  (clr_busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_level (out_level)
    );

    assign m_tdata = {7'd0, out_level, out_index};

endmodule
`default_nettype wire
